[design/plac_pkg.sv]
// Package for the path length accumulator: widths, fix kind codes,
// the job record passed from front to back, and the back-end state type.
// No dependencies.
`timescale 1ns / 1ps

package plac_pkg;

	localparam int COORD_BITS = 24;
	localparam int TOTAL_BITS = 40;
	localparam int DIST_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int RAD_BITS   = 2 * DIST_BITS;
	localparam int STEP_BITS  = $clog2(DIST_BITS);
	localparam int KIND_BITS  = 2;

	localparam int S_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((2 * DIST_BITS + TOTAL_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KIND_BITS-1:0] KIND_START = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DATA  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_STOP  = 2'd2;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [COORD_BITS-1:0] seg_dx;
		logic [COORD_BITS-1:0] seg_dy;
		logic [COORD_BITS-1:0] ret_dx;
		logic [COORD_BITS-1:0] ret_dy;
	} job_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SQUARE = 5'b00010,
		ST_SUM    = 5'b00100,
		ST_ROOT   = 5'b01000,
		ST_WRITE  = 5'b10000
	} back_state_t;

endpackage

[design/path_length_accumulator_unit.sv]
// Top level of the path length accumulator: front end, job queue, back end.
// Depends on plac_pkg, plac_front, plac_queue and plac_back.
//
// Channel   Dir  tdata (low bit up)                              tuser
// s_axis    in   pos_x[23:0], pos_y[47:24]                       kind[1:0]
// m_axis    out  segment_length[24:0], path_total[64:25],        is_stop[0]
//                return_length[89:65], zero pad [95:90]
//
// A start or unknown fix needs no root in the back end; a data fix needs one
// bit-serial square root (one root bit a cycle, 25 per distance), a stop fix
// two, for segment and return. The front end takes a fix while the two-entry
// job queue has room. Reset clears points, total and all handshake state at
// once. A stalled m_axis holds the result; the back end then waits.
`timescale 1ns / 1ps

module path_length_accumulator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [plac_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,  // pos_x, pos_y
	input  logic [plac_pkg::KIND_BITS-1:0]        s_axis_tuser,  // kind
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// segment_length, path_total, return_length
	output logic [plac_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,
	output logic [0:0]                            m_axis_tuser   // is_stop
);
	import plac_pkg::*;

	logic                  push_valid, push_ready, pop_valid, pop_ready;
	job_t                  push_job, pop_job;
	logic [DIST_BITS-1:0]  seg_len, ret_len;
	logic [TOTAL_BITS-1:0] total;
	logic                  stop;

	plac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.kind       (s_axis_tuser),
		.pos_x      (s_axis_tdata[COORD_BITS-1:0]),
		.pos_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	plac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	plac_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_job        (pop_job),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.segment_length (seg_len),
		.path_total     (total),
		.return_length  (ret_len),
		.is_stop        (stop)
	);

	assign m_axis_tdata = M_TDATA_BITS'({ret_len, total, seg_len});
	assign m_axis_tuser = stop;

endmodule

[design/plac_front.sv]
// Front end: takes position fixes, keeps start and last points, and turns each
// fix into a job with coordinate difference magnitudes. Depends on plac_pkg.
`timescale 1ns / 1ps

module plac_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [plac_pkg::KIND_BITS-1:0]      kind,
	input  logic signed [plac_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [plac_pkg::COORD_BITS-1:0] pos_y,
	output logic                                push_valid,
	input  logic                                push_ready,
	output plac_pkg::job_t                      push_job
);
	import plac_pkg::*;

	logic [COORD_BITS-1:0] origin_x_q, origin_y_q, last_x_q, last_y_q;
	logic                  take;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic [COORD_BITS:0] d;
		logic [COORD_BITS:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? (~d + 1'b1) : d;
		return m[COORD_BITS-1:0];
	endfunction

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid && push_ready;

	always_comb begin
		push_job        = '0;
		push_job.kind   = kind;
		if (kind == KIND_DATA || kind == KIND_STOP) begin
			push_job.seg_dx = abs_diff(last_x_q, pos_x);
			push_job.seg_dy = abs_diff(last_y_q, pos_y);
		end
		if (kind == KIND_STOP) begin
			push_job.ret_dx = abs_diff(origin_x_q, pos_x);
			push_job.ret_dy = abs_diff(origin_y_q, pos_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			last_x_q   <= '0;
			last_y_q   <= '0;
		end else if (take) begin
			if (kind == KIND_START) begin
				origin_x_q <= pos_x;
				origin_y_q <= pos_y;
				last_x_q   <= pos_x;
				last_y_q   <= pos_y;
			end else if (kind == KIND_DATA) begin
				last_x_q <= pos_x;
				last_y_q <= pos_y;
			end
		end
	end

endmodule

[design/plac_queue.sv]
// Short job queue between front and back end.
// Depends on plac_pkg for the job record and depth.
`timescale 1ns / 1ps

module plac_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  plac_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output plac_pkg::job_t pop_job
);
	import plac_pkg::*;

	job_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push, do_pop;

	assign push_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[design/plac_back.sv]
// Back end: squares, bit-serial integer square root, saturating total and
// the output register. Depends on plac_pkg.
`timescale 1ns / 1ps

module plac_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  plac_pkg::job_t                      pop_job,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [plac_pkg::DIST_BITS-1:0]      segment_length,
	output logic [plac_pkg::TOTAL_BITS-1:0]     path_total,
	output logic [plac_pkg::DIST_BITS-1:0]      return_length,
	output logic                                is_stop
);
	import plac_pkg::*;

	back_state_t           state_q;
	logic [KIND_BITS-1:0]  kind_q;
	logic [COORD_BITS-1:0] dx_q, dy_q, ret_dx_q, ret_dy_q;
	logic                  pass_q;
	logic [SQ_BITS-1:0]    sx_q, sy_q;
	logic [RAD_BITS-1:0]   rad_q;
	logic [DIST_BITS-1:0]  root_q;
	logic [DIST_BITS:0]    rem_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [DIST_BITS-1:0]  seg_q, ret_q;
	logic [TOTAL_BITS-1:0] total_q;

	logic                  out_valid_q;
	logic [DIST_BITS-1:0]  seg_out_q, ret_out_q;
	logic [TOTAL_BITS-1:0] total_out_q;
	logic                  stop_out_q;

	logic [DIST_BITS+2:0]  rem_sh, trial, rem_diff;
	logic                  fits;
	logic [DIST_BITS:0]    rem_next;
	logic [DIST_BITS-1:0]  root_next;
	logic [TOTAL_BITS:0]   sum_wide;
	logic [TOTAL_BITS-1:0] total_next;
	logic                  slot_free, moves;

	assign rem_sh    = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign fits      = (rem_sh >= trial);
	assign rem_diff  = rem_sh - trial;
	assign rem_next  = fits ? rem_diff[DIST_BITS:0] : rem_sh[DIST_BITS:0];
	assign root_next = {root_q[DIST_BITS-2:0], fits};

	assign moves      = (kind_q == KIND_DATA) || (kind_q == KIND_STOP);
	assign sum_wide   = {1'b0, total_q} + (TOTAL_BITS + 1)'(seg_q);
	assign total_next = !moves ? total_q :
	                    (sum_wide[TOTAL_BITS] ? '1 : sum_wide[TOTAL_BITS-1:0]);

	assign slot_free  = !out_valid_q || out_ready;
	assign pop_ready  = (state_q == ST_IDLE);

	assign out_valid      = out_valid_q;
	assign segment_length = seg_out_q;
	assign path_total     = total_out_q;
	assign return_length  = ret_out_q;
	assign is_stop        = stop_out_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q   <= pop_job.kind;
				dx_q     <= pop_job.seg_dx;
				dy_q     <= pop_job.seg_dy;
				ret_dx_q <= pop_job.ret_dx;
				ret_dy_q <= pop_job.ret_dy;
				seg_q    <= '0;
				ret_q    <= '0;
				pass_q   <= 1'b0;
			end
			ST_SQUARE: begin
				sx_q <= SQ_BITS'({{COORD_BITS{1'b0}}, dx_q} * {{COORD_BITS{1'b0}}, dx_q});
				sy_q <= SQ_BITS'({{COORD_BITS{1'b0}}, dy_q} * {{COORD_BITS{1'b0}}, dy_q});
			end
			ST_SUM: begin
				rad_q  <= RAD_BITS'(sx_q) + RAD_BITS'(sy_q);
				root_q <= '0;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
				rem_q  <= rem_next;
				root_q <= root_next;
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(DIST_BITS - 1)) begin
					if (pass_q) begin
						ret_q <= root_next;
					end else begin
						seg_q  <= root_next;
						dx_q   <= ret_dx_q;
						dy_q   <= ret_dy_q;
						pass_q <= 1'b1;
					end
				end
			end
			ST_WRITE: begin
				if (slot_free) begin
					seg_out_q   <= seg_q;
					ret_out_q   <= ret_q;
					total_out_q <= total_next;
					stop_out_q  <= (kind_q == KIND_STOP);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_WRITE && slot_free) out_valid_q <= 1'b1;
			else if (out_ready)                  out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_job.kind == KIND_DATA || pop_job.kind == KIND_STOP)
							state_q <= ST_SQUARE;
						else
							state_q <= ST_WRITE;
					end
				end
				ST_SQUARE: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_ROOT;
				ST_ROOT: begin
					if (step_q == STEP_BITS'(DIST_BITS - 1)) begin
						if (!pass_q && kind_q == KIND_STOP) state_q <= ST_SQUARE;
						else                               state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (slot_free) begin
						total_q <= total_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for path_length_accumulator_unit: directed fixes,
// random trips under several idle/stall mixes and back-pressure.
// Depends on plac_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top;
	import plac_pkg::*;

	localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd3;
	localparam logic [COORD_BITS-1:0] C_MAX = 24'h7FFFFF;
	localparam logic [COORD_BITS-1:0] C_MIN = 24'h800000;
	localparam logic [TOTAL_BITS-1:0] TOTAL_SAT = '1;
	localparam int DIR_ROWS = 20;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic [DIST_BITS-1:0]  seg;
		logic [TOTAL_BITS-1:0] total;
		logic [DIST_BITS-1:0]  ret;
		logic                  stop;
	} fix_report_t;

	typedef struct {
		logic [KIND_BITS-1:0] kind;
		int                   x;
		int                   y;
		bit                   typed;
		fix_report_t          rep;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [S_TDATA_BITS-1:0] s_axis_tdata;   // pos_x, pos_y
	logic [KIND_BITS-1:0]    s_axis_tuser;   // kind
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [M_TDATA_BITS-1:0] m_axis_tdata;   // segment_length, path_total, return_length
	logic [0:0]              m_axis_tuser;   // is_stop

	// odometer model state
	logic signed [COORD_BITS-1:0] org_x, org_y, lst_x, lst_y;
	logic [TOTAL_BITS-1:0]        odo_total;

	fix_report_t pending_reports [$];
	int          bad_reports;
	int          fixes_sent;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          hold_left;
	logic [COORD_BITS-1:0] gen_x, gen_y;
	dir_row_t    dir_tab [DIR_ROWS];

	path_length_accumulator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// floor(sqrt(dx^2 + dy^2)) between two signed points
	function automatic logic [DIST_BITS-1:0] span(logic signed [COORD_BITS-1:0] ax,
			logic signed [COORD_BITS-1:0] ay, logic signed [COORD_BITS-1:0] bx,
			logic signed [COORD_BITS-1:0] by);
		logic signed [COORD_BITS:0] dx, dy;
		logic [63:0] sq, rem, root, trial;
		dx = ax - bx;
		dy = ay - by;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
		rem = 0;
		root = 0;
		for (int k = 62; k >= 0; k -= 2) begin
			rem = (rem << 2) | ((sq >> k) & 64'd3);
			trial = (root << 2) | 64'd1;
			root = root << 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 64'd1;
			end
		end
		return root[DIST_BITS-1:0];
	endfunction

	function automatic fix_report_t predict_fix(logic [KIND_BITS-1:0] kind,
			logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y);
		fix_report_t r;
		logic [TOTAL_BITS:0] sum;
		r = '0;
		case (kind)
			KIND_START: begin
				org_x = x;
				org_y = y;
				lst_x = x;
				lst_y = y;
			end
			KIND_DATA, KIND_STOP: begin
				r.seg = span(lst_x, lst_y, x, y);
				sum = {1'b0, odo_total} + (TOTAL_BITS + 1)'(r.seg);
				odo_total = sum[TOTAL_BITS] ? TOTAL_SAT : sum[TOTAL_BITS-1:0];
				if (kind == KIND_DATA) begin
					lst_x = x;
					lst_y = y;
				end else begin
					r.ret = span(org_x, org_y, x, y);
					r.stop = 1'b1;
				end
			end
			default: ;
		endcase
		r.total = odo_total;
		return r;
	endfunction

	// expectation is queued when offered; the fix is never withdrawn
	task automatic send_fix(logic [KIND_BITS-1:0] kind, logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y, bit typed, fix_report_t typed_rep);
		fix_report_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		r = predict_fix(kind, x, y);
		pending_reports.push_back(typed ? typed_rep : r);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {y, x};
		s_axis_tuser = kind;
		if (kind != KIND_NONE) fixes_sent++;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] next_coord(logic [COORD_BITS-1:0] prev);
		logic [COORD_BITS-1:0] c;
		case ($urandom_range(7))
			0, 1: c = COORD_BITS'($urandom);
			2, 3, 4: c = prev + COORD_BITS'($urandom_range(8191)) - COORD_BITS'(4096);
			5: begin
				case ($urandom_range(3))
					0: c = C_MIN;
					1: c = C_MAX;
					2: c = '0;
					default: c = '1;
				endcase
			end
			default: c = COORD_BITS'($urandom_range(65535)) - COORD_BITS'(32768);
		endcase
		return c;
	endfunction

	// mostly start / data... / stop trips, some stray and unknown fixes
	task automatic run_trips(int count);
		int stop_at;
		int r;
		stop_at = fixes_sent + count;
		while (fixes_sent < stop_at) begin
			r = $urandom_range(99);
			gen_x = next_coord(gen_x);
			gen_y = next_coord(gen_y);
			if (r < 85) begin
				send_fix(KIND_START, gen_x, gen_y, 1'b0, '0);
				repeat ($urandom_range(1, 8)) begin
					gen_x = next_coord(gen_x);
					gen_y = next_coord(gen_y);
					send_fix(KIND_DATA, gen_x, gen_y, 1'b0, '0);
				end
				repeat ($urandom_range(1, 2)) begin
					gen_x = next_coord(gen_x);
					gen_y = next_coord(gen_y);
					send_fix(KIND_STOP, gen_x, gen_y, 1'b0, '0);
				end
			end else if (r < 92) begin
				send_fix(KIND_NONE, gen_x, gen_y, 1'b0, '0);
			end else if (r < 97) begin
				send_fix(KIND_STOP, gen_x, gen_y, 1'b0, '0);
			end else begin
				send_fix(KIND_DATA, gen_x, gen_y, 1'b0, '0);
			end
		end
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		fix_report_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.seg = m_axis_tdata[DIST_BITS-1:0];
			got.total = m_axis_tdata[DIST_BITS +: TOTAL_BITS];
			got.ret = m_axis_tdata[DIST_BITS + TOTAL_BITS +: DIST_BITS];
			got.stop = m_axis_tuser[0];
			if (pending_reports.size() == 0) begin
				bad_reports++;
				if (bad_reports <= SHOWN_MISMATCHES)
					$display("unexpected transfer: seg=%0d total=%0d ret=%0d stop=%0d",
						got.seg, got.total, got.ret, got.stop);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					bad_reports++;
					if (bad_reports <= SHOWN_MISMATCHES)
						$display("mismatch seg/total/ret/stop exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.seg, want.total, want.ret, want.stop,
							got.seg, got.total, got.ret, got.stop);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		org_x = '0;
		org_y = '0;
		lst_x = '0;
		lst_y = '0;
		odo_total = '0;
		bad_reports = 0;
		fixes_sent = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 0;
		gen_x = '0;
		gen_y = '0;

		dir_tab = '{
			'{KIND_NONE,  123, -456, 1'b1, '{25'd0, 40'd0, 25'd0, 1'b0}},
			'{KIND_STOP,  0, 0, 1'b1, '{25'd0, 40'd0, 25'd0, 1'b1}},
			'{KIND_DATA,  768, 1024, 1'b1, '{25'd1280, 40'd1280, 25'd0, 1'b0}},
			'{KIND_STOP,  768, 1024, 1'b1, '{25'd0, 40'd1280, 25'd1280, 1'b1}},
			'{KIND_START, 8388607, 8388607, 1'b1, '{25'd0, 40'd1280, 25'd0, 1'b0}},
			'{KIND_DATA,  -8388608, -8388608, 1'b0, '0},
			'{KIND_STOP,  8388607, -8388608, 1'b0, '0},
			'{KIND_STOP,  8388607, -8388608, 1'b0, '0},
			'{KIND_NONE,  -8388608, 8388607, 1'b0, '0},
			'{KIND_START, -1, -1, 1'b0, '0},
			'{KIND_DATA,  0, 0, 1'b0, '0},
			'{KIND_DATA,  1, 0, 1'b0, '0},
			'{KIND_DATA,  -8388608, 8388607, 1'b0, '0},
			'{KIND_DATA,  8388607, -8388608, 1'b0, '0},
			'{KIND_STOP,  0, 0, 1'b0, '0},
			'{KIND_START, 0, 0, 1'b0, '0},
			'{KIND_DATA,  0, 8388607, 1'b0, '0},
			'{KIND_DATA,  0, -8388608, 1'b0, '0},
			'{KIND_STOP,  -8388608, 0, 1'b0, '0},
			'{KIND_DATA,  -256, -256, 1'b0, '0}
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_fix(dir_tab[i].kind, COORD_BITS'(dir_tab[i].x), COORD_BITS'(dir_tab[i].y),
				dir_tab[i].typed, dir_tab[i].rep);

		run_trips(470);
		tx_idle_pct = 50;
		run_trips(470);
		tx_idle_pct = 0;
		rx_stall_pct = 50;
		run_trips(470);
		tx_idle_pct = 26;
		rx_stall_pct = 26;
		run_trips(470);

		// long receiver hold-off while fixes keep coming
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 600;
		run_trips(16);

		run_trips(40);

		s_axis_tvalid = 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (bad_reports == 0 && pending_reports.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
